// ----- rtl/rnf_pkg.sv -----
// rnf_pkg: shared types and constants of the rlc notch filter
// holds payload structs, register indexes and the multiplier request type
// no dependencies
`default_nettype none

package rnf_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS         = 16;
	localparam int TIME_BITS           = 24;
	localparam int DRIVE_FRAC_BITS_DEF = 16;

	// internal widths
	localparam int DRIVE_W  = 40;
	localparam int COEF_A_W = 32;
	localparam int COEF_B_W = 40;
	localparam int MUL_W    = 32;
	localparam int ACC_W    = 4 * MUL_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_R_OVER_L  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_LC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PARAMS_OK = 2'd2;

	// weight of a partial product in the accumulator, in multiplier words
	localparam logic [1:0] WGT_0 = 2'd0;
	localparam logic [1:0] WGT_1 = 2'd1;
	localparam logic [1:0] WGT_2 = 2'd2;

	typedef struct packed {
		logic                          first_of_record;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [TIME_BITS-1:0]          sample_time;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered_sample;
		logic                          saturated;
	} result_t;

	typedef struct packed {
		logic [COEF_A_W-1:0] r_over_l;
		logic [COEF_B_W-1:0] inv_lc;
		logic                params_valid;
	} coef_t;

	typedef struct packed {
		logic             issue;
		logic             clear;
		logic [1:0]       wgt;
		logic [MUL_W-1:0] op_a;
		logic [MUL_W-1:0] op_b;
	} mac_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rlc_notch_filter_top.sv -----
// rlc_notch_filter_top: series rlc notch on timestamped digitizer samples
// a filtered sample takes six products of four 32x32 partial products each through
// the one shared multiplier; item_stall holds off the next sample until the result
// has gone to the output register.
// start of record, no previous sample or invalid parameters skip the products.
// reset clears registers, filter state and output valid; depends on rnf_pkg, rnf_seq
`default_nettype none

module rlc_notch_filter_top import rnf_pkg::*; #(
	parameter int DRIVE_FRAC_BITS = DRIVE_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	coef_t     coef_q;
	seq_stat_t stat;
	result_t   seq_result;
	result_t   result_q;
	logic      result_valid_q;
	logic      start;
	logic      take;

	assign cfg_ready  = 1'b1;
	assign item_stall = stat.busy;
	assign start      = item_valid && !stat.busy;
	assign take       = stat.done && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_R_OVER_L:  coef_q.r_over_l     <= cfg_data[COEF_A_W-1:0];
				REG_INV_LC:    coef_q.inv_lc       <= cfg_data[COEF_B_W-1:0];
				REG_PARAMS_OK: coef_q.params_valid <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rnf_seq #(
		.DRIVE_FRAC_BITS (DRIVE_FRAC_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.coef   (coef_q),
		.take   (take),
		.stat   (stat),
		.result (seq_result)
	);

	// output register holds one result so the sequencer can work on the next sample while it waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= seq_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- rtl/rnf_mac.sv -----
// rnf_mac: shared 32x32 multiplier with a wide accumulator
// registered product, then weighted add into a 128-bit accumulator
// depends on rnf_pkg
`default_nettype none

module rnf_mac import rnf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mac_req_t         req,
	output logic [ACC_W-1:0]      acc
);

	logic                 vld_s1;
	logic                 clear_s1;
	logic [1:0]           wgt_s1;
	logic [2*MUL_W-1:0]   prod_s1;
	logic [ACC_W-1:0]     addend;
	logic [ACC_W-1:0]     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			clear_s1 <= req.clear;
			wgt_s1   <= req.wgt;
			prod_s1  <= req.op_a * req.op_b;
		end
	end

	always_comb begin
		unique case (wgt_s1)
			WGT_0:   addend = ACC_W'(prod_s1);
			WGT_1:   addend = ACC_W'(prod_s1) << MUL_W;
			WGT_2:   addend = ACC_W'(prod_s1) << (2 * MUL_W);
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= clear_s1 ? addend : acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- rtl/rnf_seq.sv -----
// rnf_seq: sequencer and datapath of the notch recurrence
// walks six products through the shared multiplier, rounds, sums and saturates
// depends on rnf_pkg and rnf_mac
`default_nettype none

module rnf_seq import rnf_pkg::*; #(
	parameter int DRIVE_FRAC_BITS = DRIVE_FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire item_t     item,
	input  wire coef_t     coef,
	input  wire logic      take,
	output seq_stat_t      stat,
	output result_t        result
);

	localparam int TERM_W = 61;
	localparam int SUM_W  = 64;
	localparam int V_W    = DRIVE_W + 2;
	localparam int SH_BC  = 16;
	localparam int SH_T1  = MUL_W - DRIVE_FRAC_BITS;
	localparam int SH_T23 = MUL_W;
	localparam int W2     = 2 * MUL_W;

	localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] U_MAX =
		{{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] U_MIN = ~U_MAX;
	localparam logic signed [V_W-1:0] Y_MAX =
		{{(V_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [V_W-1:0] Y_MIN = ~Y_MAX;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_ROUND  = 3'd4;
	localparam logic [2:0] ST_STORE  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	localparam logic [2:0] OP_ADT = 3'd0;
	localparam logic [2:0] OP_DT2 = 3'd1;
	localparam logic [2:0] OP_BC  = 3'd2;
	localparam logic [2:0] OP_T1  = 3'd3;
	localparam logic [2:0] OP_T2  = 3'd4;
	localparam logic [2:0] OP_T3  = 3'd5;

	logic [2:0]                    state_q;
	logic [2:0]                    op_q;
	logic [1:0]                    pp_q;

	// filter state
	logic signed [DRIVE_W-1:0]     drive_now_q;
	logic signed [DRIVE_W-1:0]     drive_before_q;
	logic signed [SAMPLE_BITS-1:0] last_sample_q;
	logic [TIME_BITS-1:0]          last_time_q;
	logic                          have_prev_q;

	// per-item working registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          dx_neg_q;
	logic [SAMPLE_BITS:0]          dx_mag_q;
	logic [TIME_BITS-1:0]          dt_q;
	logic                          du_neg_q;
	logic [DRIVE_W:0]              du_mag_q;
	logic                          up_neg_q;
	logic [DRIVE_W-1:0]            up_mag_q;
	logic [W2-1:0]                 adt_q;
	logic [W2-1:0]                 dt2_q;
	logic [TERM_W-1:0]             bc_q;
	logic [W2-1:0]                 res_q;
	logic                          clip_q;
	logic signed [SUM_W-1:0]       sum_q;
	result_t                       result_q;

	logic                          bypass;
	logic signed [SAMPLE_BITS:0]   dx;
	logic signed [DRIVE_W:0]       du;
	logic signed [SUM_W-1:0]       sum_init;
	logic [W2-1:0]                 opa;
	logic [W2-1:0]                 opb;
	mac_req_t                      req;
	logic [ACC_W-1:0]              acc;
	logic [ACC_W-1:0]              rsum;
	logic [ACC_W-1:0]              rsh;
	logic                          rraw;
	logic                          rclip;
	logic [W2-1:0]                 rres;
	logic                          sub_term;
	logic signed [V_W-1:0]         v_x;
	logic signed [V_W-1:0]         v_u;
	logic signed [V_W-1:0]         v_r;
	logic signed [V_W-1:0]         v;
	logic signed [V_W-1:0]         yf;
	logic signed [V_W-1:0]         y_sat;
	logic                          y_clip;
	logic signed [SUM_W-1:0]       un_sat;
	logic                          u_clip;

	assign bypass = !coef.params_valid || item.first_of_record || !have_prev_q;

	always_comb begin
		dx       = (SAMPLE_BITS+1)'(item.sample) - (SAMPLE_BITS+1)'(last_sample_q);
		du       = (DRIVE_W+1)'(drive_now_q) - (DRIVE_W+1)'(drive_before_q);
		sum_init = (SUM_W'(drive_now_q) <<< 1) - SUM_W'(drive_before_q);
	end

	// operand selection for the shared multiplier
	always_comb begin
		unique case (op_q)
			OP_ADT: begin
				opa = W2'(coef.r_over_l);
				opb = W2'(dt_q);
			end
			OP_DT2: begin
				opa = W2'(dt_q);
				opb = W2'(dt_q);
			end
			OP_BC: begin
				opa = W2'(coef.inv_lc);
				opb = dt2_q;
			end
			OP_T1: begin
				opa = W2'(dx_mag_q);
				opb = adt_q;
			end
			OP_T2: begin
				opa = W2'(du_mag_q);
				opb = adt_q;
			end
			OP_T3: begin
				opa = W2'(up_mag_q);
				opb = W2'(bc_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_comb begin
		req.issue = (state_q == ST_ISSUE);
		req.clear = (pp_q == 2'd0);
		unique case (pp_q)
			2'd0: begin
				req.wgt  = WGT_0;
				req.op_a = opa[MUL_W-1:0];
				req.op_b = opb[MUL_W-1:0];
			end
			2'd1: begin
				req.wgt  = WGT_1;
				req.op_a = opa[MUL_W-1:0];
				req.op_b = opb[W2-1:MUL_W];
			end
			2'd2: begin
				req.wgt  = WGT_1;
				req.op_a = opa[W2-1:MUL_W];
				req.op_b = opb[MUL_W-1:0];
			end
			default: begin
				req.wgt  = WGT_2;
				req.op_a = opa[W2-1:MUL_W];
				req.op_b = opb[W2-1:MUL_W];
			end
		endcase
	end

	rnf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.acc    (acc)
	);

	// round half away from zero on the magnitude, clip at the term limit; adt and dt2 pass unrounded
	always_comb begin
		rraw = 1'b0;
		unique case (op_q)
			OP_BC: begin
				rsum = acc + (ACC_W'(1) << (SH_BC - 1));
				rsh  = rsum >> SH_BC;
			end
			OP_T1: begin
				rsum = acc + (ACC_W'(1) << (SH_T1 - 1));
				rsh  = rsum >> SH_T1;
			end
			OP_T2, OP_T3: begin
				rsum = acc + (ACC_W'(1) << (SH_T23 - 1));
				rsh  = rsum >> SH_T23;
			end
			default: begin
				rraw = 1'b1;
				rsum = acc;
				rsh  = acc;
			end
		endcase
		rclip = !rraw && ((|rsh[ACC_W-1:TERM_W]) || (rsh[TERM_W-1:0] > TERM_LIM));
		if (rraw) begin
			rres = acc[W2-1:0];
		end else if (rclip) begin
			rres = W2'(TERM_LIM);
		end else begin
			rres = W2'(rsh[TERM_W-1:0]);
		end
	end

	// t1 adds with the sign of dx, t2 and t3 subtract with their own signs
	always_comb begin
		unique case (op_q)
			OP_T1:   sub_term = dx_neg_q;
			OP_T2:   sub_term = !du_neg_q;
			default: sub_term = !up_neg_q;
		endcase
	end

	// output value and next drive, both saturated
	always_comb begin
		v_x = V_W'(x_q);
		v_u = V_W'(drive_now_q);
		v_r = V_W'(1) <<< (DRIVE_FRAC_BITS - 1);
		v   = (v_x <<< DRIVE_FRAC_BITS) - v_u + v_r;
		yf  = v >>> DRIVE_FRAC_BITS;
		y_clip = 1'b0;
		if (yf > Y_MAX) begin
			y_sat  = Y_MAX;
			y_clip = 1'b1;
		end else if (yf < Y_MIN) begin
			y_sat  = Y_MIN;
			y_clip = 1'b1;
		end else begin
			y_sat = yf;
		end
		u_clip = 1'b0;
		if (sum_q > U_MAX) begin
			un_sat = U_MAX;
			u_clip = 1'b1;
		end else if (sum_q < U_MIN) begin
			un_sat = U_MIN;
			u_clip = 1'b1;
		end else begin
			un_sat = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_ADT;
			pp_q           <= 2'd0;
			drive_now_q    <= '0;
			drive_before_q <= '0;
			last_sample_q  <= '0;
			last_time_q    <= '0;
			have_prev_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_sample_q <= item.sample;
						last_time_q   <= item.sample_time;
						have_prev_q   <= 1'b1;
						op_q          <= OP_ADT;
						pp_q          <= 2'd0;
						if (bypass) begin
							drive_now_q    <= '0;
							drive_before_q <= '0;
							state_q        <= ST_DONE;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (op_q == OP_T3) begin
						state_q <= ST_FINISH;
					end else begin
						op_q    <= op_q + 3'd1;
						state_q <= ST_ISSUE;
					end
				end
				ST_FINISH: begin
					drive_before_q <= drive_now_q;
					drive_now_q    <= un_sat[DRIVE_W-1:0];
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q      <= item.sample;
					dx_neg_q <= dx[SAMPLE_BITS];
					dx_mag_q <= dx[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dx) : (SAMPLE_BITS+1)'(dx);
					dt_q     <= item.sample_time - last_time_q;
					clip_q   <= 1'b0;
					if (!coef.params_valid) begin
						result_q.filtered_sample <= '0;
					end else begin
						result_q.filtered_sample <= item.sample;
					end
					result_q.saturated <= 1'b0;
				end
			end
			ST_SETUP: begin
				du_neg_q <= du[DRIVE_W];
				du_mag_q <= du[DRIVE_W] ? (DRIVE_W+1)'(-du) : (DRIVE_W+1)'(du);
				up_neg_q <= drive_before_q[DRIVE_W-1];
				up_mag_q <= drive_before_q[DRIVE_W-1] ? DRIVE_W'(-drive_before_q)
					: DRIVE_W'(drive_before_q);
				sum_q    <= sum_init;
			end
			ST_ROUND: begin
				res_q  <= rres;
				clip_q <= clip_q | rclip;
			end
			ST_STORE: begin
				unique case (op_q)
					OP_ADT: adt_q <= res_q;
					OP_DT2: dt2_q <= res_q;
					OP_BC:  bc_q  <= res_q[TERM_W-1:0];
					default: begin
						if (sub_term) begin
							sum_q <= sum_q - SUM_W'(res_q);
						end else begin
							sum_q <= sum_q + SUM_W'(res_q);
						end
					end
				endcase
			end
			ST_FINISH: begin
				result_q.filtered_sample <= y_sat[SAMPLE_BITS-1:0];
				result_q.saturated       <= clip_q | y_clip | u_clip;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign result    = result_q;

endmodule

`default_nettype wire

// ----- dv/rlc_notch_filter_top_tb.sv -----
// rlc_notch_filter_top_tb: self-checking bench for the rlc notch filter top level
// streams timestamped sample records under random idling and back-pressure and
// checks each filtered sample against an in-bench predictor; needs rnf_pkg, rlc_notch_filter_top
`timescale 1ns / 100ps

module rlc_notch_filter_top_tb;
	import rnf_pkg::*;

	localparam int FRAC           = DRIVE_FRAC_BITS_DEF;
	localparam int LONG_HOLD      = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 60;

	// index past the end of the register list, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [63:0] DRIVE_HI  = (64'sd1 <<< (DRIVE_W - 1)) - 1;
	localparam logic signed [63:0] DRIVE_LO  = -(64'sd1 <<< (DRIVE_W - 1));
	localparam logic signed [63:0] SAMPLE_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [63:0] SAMPLE_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam logic [127:0]       TERM_CAP  = 128'd1 << 60;

	typedef struct packed {
		logic              clip;
		logic signed [63:0] val;
	} term_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item_bus;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result_bus;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register shadow and filter state of the predictor
	logic [COEF_A_W-1:0]    reg_r_over_l;
	logic [COEF_B_W-1:0]    reg_inv_lc;
	logic                   reg_params_ok;
	logic signed [63:0]     flt_prev_sample;
	logic [TIME_BITS-1:0]   flt_prev_time;
	logic signed [63:0]     flt_drive;
	logic signed [63:0]     flt_drive_old;
	logic                   flt_primed;

	result_t pending_results[$];
	result_t oldest_result;
	int      mismatch_count;
	int      samples_sent;
	int      quiet_cycles;
	bit      sender_idles;
	bit      receiver_idles;
	int      hold_requests;
	int      holds_served;
	int      hold_left;
	int      burst_left;

	rlc_notch_filter_top #(
		.DRIVE_FRAC_BITS(FRAC)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item_bus),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_bus),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round(s * m / 2^sh), half away from zero, magnitude capped at 2^60
	function automatic term_t round_product(input logic signed [63:0] s, input logic [63:0] m,
		input int sh);
		logic [63:0]  mag;
		logic [127:0] full;
		term_t        r;
		mag    = s[63] ? (~s + 64'd1) : s;
		full   = ({64'd0, mag} * {64'd0, m} + (128'd1 << (sh - 1))) >> sh;
		r.clip = full > TERM_CAP;
		r.val  = r.clip ? (64'sd1 <<< 60) : full[63:0];
		if (s[63])
			r.val = -r.val;
		return r;
	endfunction

	function automatic result_t predict_notch(input item_t it);
		logic signed [63:0]   x, u, up, v, un, yy;
		logic [TIME_BITS-1:0] dt;
		logic [63:0]          a_dt;
		term_t                bc, t1, t2, t3;
		logic                 clip;
		result_t              r;
		x    = {{(64 - SAMPLE_BITS){it.sample[SAMPLE_BITS-1]}}, it.sample};
		clip = 1'b0;
		if (!reg_params_ok) begin
			flt_drive     = '0;
			flt_drive_old = '0;
			yy            = '0;
		end else if (it.first_of_record || !flt_primed) begin
			flt_drive     = '0;
			flt_drive_old = '0;
			yy            = x;
		end else begin
			u    = flt_drive;
			up   = flt_drive_old;
			v    = (x <<< FRAC) - u;
			dt   = it.sample_time - flt_prev_time;
			a_dt = 64'(reg_r_over_l) * 64'(dt);
			bc   = round_product(64'(reg_inv_lc), 64'(dt) * 64'(dt), 16);
			t1   = round_product(x - flt_prev_sample, a_dt, 32 - FRAC);
			t2   = round_product(u - up, a_dt, 32);
			t3   = round_product(up, bc.val, 32);
			clip = bc.clip | t1.clip | t2.clip | t3.clip;
			un   = 2 * u - up + t1.val - t2.val - t3.val;
			yy   = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
			if (yy > SAMPLE_HI) begin
				yy   = SAMPLE_HI;
				clip = 1'b1;
			end
			if (yy < SAMPLE_LO) begin
				yy   = SAMPLE_LO;
				clip = 1'b1;
			end
			if (un > DRIVE_HI) begin
				un   = DRIVE_HI;
				clip = 1'b1;
			end
			if (un < DRIVE_LO) begin
				un   = DRIVE_LO;
				clip = 1'b1;
			end
			flt_drive_old = u;
			flt_drive     = un;
		end
		flt_prev_sample   = x;
		flt_prev_time     = it.sample_time;
		flt_primed        = 1'b1;
		r.filtered_sample = yy[SAMPLE_BITS-1:0];
		r.saturated       = clip;
		return r;
	endfunction

	function automatic item_t sample_at(input logic first, input logic [SAMPLE_BITS-1:0] x,
		input logic [TIME_BITS-1:0] t);
		item_t it;
		it.first_of_record = first;
		it.sample          = x;
		it.sample_time     = t;
		return it;
	endfunction

	// called at a falling edge; valid stays high so back-to-back requests need no toggle
	task automatic send_sample(input item_t it);
		int gap;
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_bus   <= it;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(predict_notch(it));
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_filter(input logic [COEF_A_W-1:0] a, input logic [COEF_B_W-1:0] b,
		input logic ok);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		int                    k;
		drain_pipeline();
		for (k = 0; k < 4; k++) begin
			case (k)
				0: begin
					idx  = REG_SPARE;
					data = CFG_DATA_W'({$urandom, $urandom});
				end
				1: begin
					idx  = REG_R_OVER_L;
					data = {8'($urandom), a};
				end
				2: begin
					idx  = REG_INV_LC;
					data = b;
				end
				default: begin
					idx  = REG_PARAMS_OK;
					data = {39'($urandom), ok};
				end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				REG_R_OVER_L:  reg_r_over_l  = data[COEF_A_W-1:0];
				REG_INV_LC:    reg_inv_lc    = data[COEF_B_W-1:0];
				REG_PARAMS_OK: reg_params_ok = data[0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one waveform record with random content; sometimes broken or noisy
	task automatic send_record(input int len);
		logic [TIME_BITS-1:0] stamp;
		int                   step, amp, n;
		bit                   broken;
		item_t                it;
		stamp  = TIME_BITS'($urandom_range(0, 24'hFFFFFF));
		amp    = 1 << $urandom_range(0, 15);
		broken = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 9))
			0:       step = $urandom_range(0, 3);
			1:       step = $urandom_range(10000, 24'hFFFFFF);
			default: step = $urandom_range(20, 800);
		endcase
		for (n = 0; n < len; n++) begin
			it.first_of_record = (n == 0) ? !broken : ($urandom_range(0, 39) == 0);
			case ($urandom_range(0, 19))
				0:       it.sample = SAMPLE_BITS'($urandom);
				1:       it.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				default: it.sample = SAMPLE_BITS'($urandom_range(0, 2 * amp) - amp);
			endcase
			if (n > 0) begin
				case ($urandom_range(0, 29))
					0:       stamp = stamp - TIME_BITS'($urandom_range(1, 5000));
					1:       stamp = TIME_BITS'($urandom);
					default: stamp = stamp + TIME_BITS'(step + $urandom_range(0, step / 8));
				endcase
			end
			it.sample_time = stamp;
			send_sample(it);
		end
	endtask

	// parameters are invalid out of reset, so every output is zero
	task automatic test_invalid_after_reset();
		send_sample(sample_at(1'b0, 16'd1234, 24'd100));
		send_sample(sample_at(1'b0, 16'h8000, 24'd300));
		send_sample(sample_at(1'b1, 16'h7FFF, 24'd500));
	endtask

	task automatic test_directed_cases();
		program_filter(32'd1_000_000, 40'd70_000_000, 1'b1);
		// parameters turned on mid-stream: filter runs from zero drives
		send_sample(sample_at(1'b0, 16'd200, 24'd700));
		send_sample(sample_at(1'b1, 16'h7FFF, 24'd1000));
		send_sample(sample_at(1'b0, 16'h8000, 24'd1200));
		send_sample(sample_at(1'b0, 16'h8000, 24'd1400));
		send_sample(sample_at(1'b0, 16'h7FFF, 24'd1400));
		// timestamp going backwards gives a huge interval
		send_sample(sample_at(1'b0, 16'd0, 24'd1000));
		send_sample(sample_at(1'b0, 16'd100, 24'd1300));
		send_sample(sample_at(1'b1, 16'h8000, 24'hFFFFFF));
		send_sample(sample_at(1'b0, 16'd5, 24'd100));

		program_filter('1, '1, 1'b1);
		send_sample(sample_at(1'b1, 16'd0, 24'd0));
		send_sample(sample_at(1'b0, 16'h7FFF, 24'hFFFFFF));
		send_sample(sample_at(1'b0, 16'h8000, 24'hFFFFFE));
		send_sample(sample_at(1'b0, 16'h7FFF, 24'hFFFFFD));

		program_filter('0, '0, 1'b1);
		send_sample(sample_at(1'b1, 16'd7, 24'd10));
		send_sample(sample_at(1'b0, 16'h8000, 24'd20));
		send_sample(sample_at(1'b0, 16'h7FFF, 24'd30));

		program_filter(32'd1_000_000, 40'd70_000_000, 1'b0);
		send_sample(sample_at(1'b1, 16'h7FFF, 24'd40));
		send_sample(sample_at(1'b0, 16'h8000, 24'd240));
		send_sample(sample_at(1'b0, 16'd77, 24'd440));
	endtask

	task automatic test_random_records(input int target);
		logic [COEF_A_W-1:0] a;
		logic [COEF_B_W-1:0] b;
		logic                ok;
		int                  phase_end;
		target = samples_sent + target;
		while (samples_sent < target) begin
			ok = 1'b1;
			case ($urandom_range(0, 9))
				0: begin
					a = '0;
					b = '0;
				end
				1: begin
					a = '1;
					b = '1;
				end
				2: begin
					a  = $urandom;
					b  = COEF_B_W'({$urandom, $urandom});
					ok = 1'b0;
				end
				3: begin
					a = $urandom;
					b = COEF_B_W'({$urandom, $urandom});
				end
				default: begin
					a = $urandom_range(1 << 12, 1 << 21);
					b = COEF_B_W'($urandom_range(1 << 16, 1 << 30));
				end
			endcase
			program_filter(a, b, ok);
			phase_end = samples_sent + 150;
			while (samples_sent < phase_end && samples_sent < target) begin
				sender_idles   = ($urandom_range(0, 3) != 0);
				receiver_idles = ($urandom_range(0, 3) != 0);
				send_record(($urandom_range(0, 7) == 0) ? $urandom_range(1, 4)
					: $urandom_range(5, 40));
			end
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_result_backpressure();
		program_filter(32'd600_000, 40'd20_000_000, 1'b1);
		sender_idles = 1'b0;
		@(posedge clk);
		hold_requests++;
		@(negedge clk);
		send_record(40);
	endtask

	task automatic test_steady_stream(input int count);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		program_filter(32'd2_000_000, 40'd100_000_000, 1'b1);
		while (count > 0) begin
			send_record(30);
			count -= 30;
		end
	endtask

	// stall generator for the result side
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = holds_served + 1;
			hold_left    = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			result_stall <= 1'b1;
		end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(1, 15) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d sat %0b", $time,
					result_bus.filtered_sample, result_bus.saturated);
				mismatch_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (result_bus.filtered_sample !== oldest_result.filtered_sample) begin
					$display("%0t: filtered_sample expected %0d got %0d", $time,
						oldest_result.filtered_sample, result_bus.filtered_sample);
					mismatch_count++;
				end
				if (result_bus.saturated !== oldest_result.saturated) begin
					$display("%0t: saturated expected %0b got %0b", $time,
						oldest_result.saturated, result_bus.saturated);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
			|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		item_bus        = '0;
		result_stall    = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_R_OVER_L;
		cfg_data        = '0;
		reg_r_over_l    = '0;
		reg_inv_lc      = '0;
		reg_params_ok   = 1'b0;
		flt_prev_sample = '0;
		flt_prev_time   = '0;
		flt_drive       = '0;
		flt_drive_old   = '0;
		flt_primed      = 1'b0;
		mismatch_count  = 0;
		samples_sent    = 0;
		quiet_cycles    = 0;
		hold_requests   = 0;
		holds_served    = 0;
		hold_left       = 0;
		burst_left      = 0;
		sender_idles    = 1'b1;
		receiver_idles  = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_invalid_after_reset();
		test_directed_cases();
		test_random_records(1580);
		test_result_backpressure();
		test_steady_stream(120);

		drain_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rnf_pkg.sv
rtl/rnf_mac.sv
rtl/rnf_seq.sv
rtl/rlc_notch_filter_top.sv
dv/rlc_notch_filter_top_tb.sv
